// File: rtl/stws_pkg.sv
// Shared types, widths and constants of the steering to wheel speed unit.
// Used by stws_cordic and steer_to_wheel_speeds_unit; no dependencies.
package stws_pkg;

    localparam int XW  = 23;   // CORDIC x/y, signed
    localparam int ZW  = 27;   // CORDIC angle, signed Q.24
    localparam int CW  = 21;   // clamped cos/sin, unsigned
    localparam int NW  = 36;   // numerator magnitude and denominator of k
    localparam int QKW = 29;   // quotient bits of k (Q.28, at most one)
    localparam int KW  = 30;   // signed k in Q.28
    localparam int SPW = 23;   // speed times 125, signed
    localparam int PW  = 53;   // speed * 125 * k, signed
    localparam int MW  = 22;   // rate magnitude before division by the radius
    localparam int RW  = 10;   // wheel radius

    localparam logic signed [XW-1:0] CORDIC_X0   = 23'sd1048576;
    localparam logic [14:0]          ANGLE_LIMIT = 15'd12868;
    localparam logic signed [KW-1:0] KQ_ONE      = 30'sd268435456;

    localparam logic [1:0] REG_TRACK_WIDTH  = 2'd0;
    localparam logic [1:0] REG_WHEELBASE    = 2'd1;
    localparam logic [1:0] REG_LEFT_RADIUS  = 2'd2;
    localparam logic [1:0] REG_RIGHT_RADIUS = 2'd3;

    typedef struct packed {
        logic signed [SPW-1:0] sp125;
        logic                  spd_zero;
        logic                  ang_zero;
        logic                  ang_pos;
    } cmd_side_t;

    typedef struct packed {
        cmd_side_t cmd;
        logic      num_neg;
        logic      den_zero;
    } kq_side_t;

    typedef struct packed {
        logic spd_zero;
        logic left_neg;
        logic left_zero;
        logic right_zero;
    } rate_side_t;

    // Arctangent of 2^-idx in Q.24, rounded.
    function automatic logic signed [ZW-1:0] atan_q24(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 27'sd13176795;
            1:  v = 27'sd7778716;
            2:  v = 27'sd4110060;
            3:  v = 27'sd2086331;
            4:  v = 27'sd1047214;
            5:  v = 27'sd524117;
            6:  v = 27'sd262123;
            7:  v = 27'sd131069;
            8:  v = 27'sd65536;
            9:  v = 27'sd32768;
            10: v = 27'sd16384;
            11: v = 27'sd8192;
            12: v = 27'sd4096;
            13: v = 27'sd2048;
            14: v = 27'sd1024;
            15: v = 27'sd512;
            16: v = 27'sd256;
            17: v = 27'sd128;
            18: v = 27'sd64;
            19: v = 27'sd32;
            20: v = 27'sd16;
            21: v = 27'sd8;
            22: v = 27'sd4;
            23: v = 27'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/steer_to_wheel_speeds_unit.sv
// Steering command to wheel rates, computed by a pipeline from start to done.
// One command per cycle; busy stays low. The depth is set by the CORDIC stages and
// the two bit-per-stage dividers (29 bits for the wheel ratio, 22 for the rate).
// Reset clears the pipeline valid bits and loads the geometry registers with
// 400, 300, 100 and 100 mm. Results appear on done for one cycle and cannot be held.
module steer_to_wheel_speeds_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] speed,
    input  logic signed [14:0] rudder_angle,
    output logic               done,
    output logic signed [15:0] left_rate,
    output logic signed [15:0] right_rate,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data
);
    import stws_pkg::*;

    localparam int LATENCY = CORDIC_STEPS + 58;

    // Geometry registers.
    logic [11:0]   track_width_reg;
    logic [11:0]   wheelbase_reg;
    logic [RW-1:0] left_radius_reg;
    logic [RW-1:0] right_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_width_reg  <= 12'd400;
            wheelbase_reg    <= 12'd300;
            left_radius_reg  <= 10'd100;
            right_radius_reg <= 10'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRACK_WIDTH:  track_width_reg  <= cfg_data;
                REG_WHEELBASE:    wheelbase_reg    <= cfg_data;
                REG_LEFT_RADIUS:  left_radius_reg  <= cfg_data[RW-1:0];
                REG_RIGHT_RADIUS: right_radius_reg <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: angle magnitude, limited to a quarter turn, and speed times 125.
    logic [14:0]          ang_mag;
    logic [14:0]          ang_lim;
    logic                 s0_valid_reg;
    logic signed [ZW-1:0] s0_z_reg;
    cmd_side_t            s0_side_reg;
    cmd_side_t            s0_side_next;

    always_comb
    begin
        ang_mag = rudder_angle[14] ? 15'(-rudder_angle) : 15'(rudder_angle);
        ang_lim = (ang_mag > ANGLE_LIMIT) ? ANGLE_LIMIT : ang_mag;
        s0_side_next.sp125    = SPW'(speed) * 23'sd125;
        s0_side_next.spd_zero = (speed == 16'sd0);
        s0_side_next.ang_zero = (rudder_angle == 15'sd0);
        s0_side_next.ang_pos  = !rudder_angle[14] && (rudder_angle != 15'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_z_reg    <= ZW'(ang_lim) <<< 11;
        s0_side_reg <= s0_side_next;
    end

    logic                 cor_valid;
    logic signed [XW-1:0] cor_x;
    logic signed [XW-1:0] cor_y;
    cmd_side_t            cor_side;

    stws_cordic #(
        .STEPS (CORDIC_STEPS),
        .SW    ($bits(cmd_side_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_z      (s0_z_reg),
        .in_side   (s0_side_reg),
        .out_valid (cor_valid),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_side  (cor_side)
    );

    // Stage 1: clamp cos and sin at zero and scale by the geometry.
    logic [CW-1:0] cos_c;
    logic [CW-1:0] sin_c;
    logic          s1_valid_reg;
    logic [33:0]   s1_lc_reg;
    logic [32:0]   s1_ws_reg;
    cmd_side_t     s1_side_reg;

    assign cos_c = cor_x[XW-1] ? '0 : cor_x[CW-1:0];
    assign sin_c = cor_y[XW-1] ? '0 : cor_y[CW-1:0];

    // Stage 2: numerator and denominator of the inner wheel ratio.
    logic [NW-1:0] num_diff;
    logic [NW-1:0] num_mag;
    logic          s2_valid_reg;
    logic [NW-1:0] s2_num_reg;
    logic [NW-1:0] s2_den_reg;
    kq_side_t      s2_side_reg;
    kq_side_t      s2_side_next;

    always_comb
    begin
        num_diff = {2'b0, s1_lc_reg} - {3'b0, s1_ws_reg};
        num_mag  = num_diff[NW-1] ? (~num_diff + 1'b1) : num_diff;
        s2_side_next.cmd      = s1_side_reg;
        s2_side_next.num_neg  = num_diff[NW-1];
        s2_side_next.den_zero = (s1_lc_reg == '0) && (s1_ws_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cor_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lc_reg   <= 34'(cos_c) * 34'({wheelbase_reg, 1'b0});
        s1_ws_reg   <= 33'(sin_c) * 33'(track_width_reg);
        s1_side_reg <= cor_side;
        s2_num_reg  <= num_mag;
        s2_den_reg  <= {2'b0, s1_lc_reg} + {3'b0, s1_ws_reg};
        s2_side_reg <= s2_side_next;
    end

    logic           dk_valid;
    logic [QKW-1:0] dk_q;
    kq_side_t       dk_side;

    stws_div #(
        .DW (NW),
        .QW (QKW),
        .SW ($bits(kq_side_t))
    ) u_div_k (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_hi     (s2_num_reg),
        .in_lo     ('0),
        .in_b      (s2_den_reg),
        .in_side   (s2_side_reg),
        .out_valid (dk_valid),
        .out_q     (dk_q),
        .out_side  (dk_side)
    );

    // Stage 3: signed ratio, steered to the inner wheel; the outer wheel takes one.
    logic signed [KW-1:0] kq;
    logic                 left_inner;
    logic                 right_inner;
    logic                 s3_valid_reg;
    logic signed [KW-1:0] s3_kl_reg;
    logic signed [KW-1:0] s3_kr_reg;
    logic signed [SPW-1:0] s3_sp_reg;
    rate_side_t           s3_side_reg;
    rate_side_t           s3_side_next;

    always_comb
    begin
        kq          = dk_side.num_neg ? -$signed({1'b0, dk_q}) : $signed({1'b0, dk_q});
        left_inner  = !dk_side.cmd.ang_zero && !dk_side.cmd.ang_pos;
        right_inner = dk_side.cmd.ang_pos;
        s3_side_next.spd_zero   = dk_side.cmd.spd_zero;
        s3_side_next.left_neg   = 1'b0;
        s3_side_next.left_zero  = (left_radius_reg == '0) || (left_inner && dk_side.den_zero);
        s3_side_next.right_zero = (right_radius_reg == '0) || (right_inner && dk_side.den_zero);
    end

    // Stage 4: products; stage 5: magnitudes with the 2^29 scale removed.
    logic                 s4_valid_reg;
    logic signed [PW-1:0] s4_pl_reg;
    logic signed [PW-1:0] s4_pr_reg;
    rate_side_t           s4_side_reg;

    logic [PW-1:0]        mag_l;
    logic [PW-1:0]        mag_r;
    logic                 s5_valid_reg;
    logic [MW-1:0]        s5_ml_reg;
    logic [MW-1:0]        s5_mr_reg;
    logic                 s5_rneg_reg;
    rate_side_t           s5_side_reg;
    rate_side_t           s5_side_next;

    always_comb
    begin
        mag_l = s4_pl_reg[PW-1] ? PW'(-s4_pl_reg) : PW'(s4_pl_reg);
        mag_r = s4_pr_reg[PW-1] ? PW'(-s4_pr_reg) : PW'(s4_pr_reg);
        s5_side_next          = s4_side_reg;
        s5_side_next.left_neg = s4_pl_reg[PW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= dk_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_kl_reg   <= (left_inner) ? kq : KQ_ONE;
        s3_kr_reg   <= (right_inner) ? kq : KQ_ONE;
        s3_sp_reg   <= dk_side.cmd.sp125;
        s3_side_reg <= s3_side_next;
        s4_pl_reg   <= PW'(s3_sp_reg) * PW'(s3_kl_reg);
        s4_pr_reg   <= PW'(s3_sp_reg) * PW'(s3_kr_reg);
        s4_side_reg <= s3_side_reg;
        s5_ml_reg   <= mag_l[MW+28:29];
        s5_mr_reg   <= mag_r[MW+28:29];
        s5_rneg_reg <= s4_pr_reg[PW-1];
        s5_side_reg <= s5_side_next;
    end

    logic          dl_valid;
    logic [MW-1:0] dl_q;
    rate_side_t    dl_side;
    logic          dr_valid;
    logic [MW-1:0] dr_q;
    logic          dr_neg;

    stws_div #(
        .DW (RW),
        .QW (MW),
        .SW ($bits(rate_side_t))
    ) u_div_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_hi     (RW'(s5_ml_reg[MW-1])),
        .in_lo     (s5_ml_reg[MW-2:0]),
        .in_b      (left_radius_reg),
        .in_side   (s5_side_reg),
        .out_valid (dl_valid),
        .out_q     (dl_q),
        .out_side  (dl_side)
    );

    stws_div #(
        .DW (RW),
        .QW (MW),
        .SW (1)
    ) u_div_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_hi     (RW'(s5_mr_reg[MW-1])),
        .in_lo     (s5_mr_reg[MW-2:0]),
        .in_b      (right_radius_reg),
        .in_side   (s5_rneg_reg),
        .out_valid (dr_valid),
        .out_q     (dr_q),
        .out_side  (dr_neg)
    );

    // Signed rate with clipping; the top bit of the result is the clip flag.
    function automatic logic [16:0] clip_rate(input logic [MW-1:0] mag, input logic neg);
        logic [MW-1:0] nmag;
        logic [16:0]   res;
        nmag = -mag;
        if (!neg && (mag > 22'd32767))
        begin
            res = {1'b1, 16'h7fff};
        end
        else if (neg && (mag > 22'd32768))
        begin
            res = {1'b1, 16'h8000};
        end
        else
        begin
            res = {1'b0, neg ? nmag[15:0] : mag[15:0]};
        end
        return res;
    endfunction

    logic [16:0] left_clip;
    logic [16:0] right_clip;
    logic        flag_next;

    always_comb
    begin
        left_clip  = clip_rate(dl_q, dl_side.left_neg);
        right_clip = clip_rate(dr_q, dr_neg);
        flag_next  = dl_valid && !dl_side.spd_zero
                     && (dl_side.left_zero || dl_side.right_zero
                         || (!dl_side.left_zero && left_clip[16])
                         || (!dl_side.right_zero && right_clip[16]));
    end

    logic               done_reg;
    logic               saturated_reg;
    logic signed [15:0] left_rate_reg;
    logic signed [15:0] right_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= dl_valid;
            saturated_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_rate_reg  <= (dl_side.spd_zero || dl_side.left_zero) ? '0 : left_clip[15:0];
        right_rate_reg <= (dl_side.spd_zero || dl_side.right_zero) ? '0 : right_clip[15:0];
    end

    assign done       = done_reg;
    assign saturated  = saturated_reg;
    assign left_rate  = left_rate_reg;
    assign right_rate = right_rate_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("request did not complete after the pipeline latency");

    a_flag_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        saturated |-> done)
        else $error("saturation flag raised without a result");

    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (dl_valid && dl_side.spd_zero) |=>
            (left_rate == 16'sd0 && right_rate == 16'sd0 && !saturated))
        else $error("zero speed request gave nonzero rates or a flag");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dl_valid == dr_valid)
        else $error("left and right rate dividers out of step");

endmodule

// File: rtl/stws_cordic.sv
// Rotation-mode CORDIC pipeline, one register stage per iteration.
// Depends on stws_pkg for widths, the start vector and the arctangent table.
module stws_cordic #(
    parameter int STEPS = 16,
    parameter int SW    = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [stws_pkg::ZW-1:0]   in_z,
    input  logic [SW-1:0]                    in_side,
    output logic                             out_valid,
    output logic signed [stws_pkg::XW-1:0]   out_x,
    output logic signed [stws_pkg::XW-1:0]   out_y,
    output logic [SW-1:0]                    out_side
);
    import stws_pkg::*;

    logic                 valid_reg [STEPS];
    logic signed [XW-1:0] x_reg     [STEPS];
    logic signed [XW-1:0] y_reg     [STEPS];
    logic signed [ZW-1:0] z_reg     [STEPS];
    logic [SW-1:0]        side_reg  [STEPS];

    genvar i;
    for (i = 0; i < STEPS; i++)
    begin : g_step
        logic                 v_in;
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic [SW-1:0]        s_in;

        if (i == 0)
        begin : g_first
            assign v_in = in_valid;
            assign x_in = CORDIC_X0;
            assign y_in = '0;
            assign z_in = in_z;
            assign s_in = in_side;
        end
        else
        begin : g_next
            assign v_in = valid_reg[i-1];
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= v_in;
            end
        end

        // Arithmetic shifts give the floor of the scaled terms.
        always_ff @(posedge clk)
        begin
            side_reg[i] <= s_in;
            if (!z_in[ZW-1])
            begin
                x_reg[i] <= x_in - (y_in >>> i);
                y_reg[i] <= y_in + (x_in >>> i);
                z_reg[i] <= z_in - atan_q24(i);
            end
            else
            begin
                x_reg[i] <= x_in + (y_in >>> i);
                y_reg[i] <= y_in - (x_in >>> i);
                z_reg[i] <= z_in + atan_q24(i);
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_x     = x_reg[STEPS-1];
    assign out_y     = y_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// File: rtl/stws_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Gives floor({hi, lo} / b) for hi < 2*b; no package dependency.
module stws_div #(
    parameter int DW = 36,
    parameter int QW = 29,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_hi,
    input  logic [QW-2:0] in_lo,
    input  logic [DW-1:0] in_b,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_q,
    output logic [SW-1:0] out_side
);

    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-2:0] lo_reg    [QW];
    logic [QW-1:0] q_reg     [QW];
    logic [DW-1:0] b_reg     [QW];
    logic [SW-1:0] side_reg  [QW];

    genvar i;
    for (i = 0; i < QW; i++)
    begin : g_stage
        logic          v_in;
        logic [DW:0]   r_in;
        logic [QW-2:0] lo_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] b_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   diff;
        logic          q_bit;

        if (i == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign r_in  = {1'b0, in_hi};
            assign lo_in = in_lo;
            assign q_in  = '0;
            assign b_in  = in_b;
            assign s_in  = in_side;
        end
        else
        begin : g_next
            assign v_in  = valid_reg[i-1];
            assign r_in  = {rem_reg[i-1], lo_reg[i-1][QW-2]};
            assign lo_in = {lo_reg[i-1][QW-3:0], 1'b0};
            assign q_in  = q_reg[i-1];
            assign b_in  = b_reg[i-1];
            assign s_in  = side_reg[i-1];
        end

        assign diff  = r_in - {1'b0, b_in};
        assign q_bit = r_in >= {1'b0, b_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= q_bit ? diff[DW-1:0] : r_in[DW-1:0];
            lo_reg[i]   <= lo_in;
            q_reg[i]    <= {q_in[QW-2:0], q_bit};
            b_reg[i]    <= b_in;
            side_reg[i] <= s_in;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
